@@ rtl/rs3_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rs3_pkg: shared types and constants for the RGB 3x3 sharpen filter
// Pixel word layout, window type, configuration indexes and defaults.
// ----------------------------------------------------------------------------
package rs3_pkg;

    localparam int CHAN_W = 8;
    localparam int WORD_W = 3 * CHAN_W;   // blue 7:0, green 15:8, red 23:16
    localparam int CFG_W  = 11;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;

    localparam logic [CFG_W-1:0] DIM_RESET = 11'd1024;

    typedef logic [WORD_W-1:0] pixel_t;

    // 3x3 window, index col*3+row; col 0 oldest, row 0 top
    typedef logic [8:0][WORD_W-1:0] win_t;

    typedef enum logic [0:0] {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } cfg_index_t;

endpackage

`default_nettype wire

@@ rtl/rgb_sharpen_3x3.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rgb_sharpen_3x3: streaming 3x3 sharpen filter on RGB pixels
// Raster-order pixels in, sharpened clamped pixels out, zero padding.
// ----------------------------------------------------------------------------
// Takes one transaction per clock with no bubbles while the output is not
// stalled. Each input transaction is registered together with the line store
// read of its column; when it leaves that stage the window shifts, the line
// store is written back and the result register is loaded. After each
// frame of frame_width*frame_height pixels, send frame_width+1
// transactions with tuser set to flush the last row; the result for pixel
// (i,j) comes out for input transaction i*W+j+W+1, and tlast marks the last
// pixel of the frame. Change frame_width and frame_height only between
// frames while the block is empty.
// ----------------------------------------------------------------------------
module rgb_sharpen_3x3 #(
    parameter int MAX_WIDTH  = rs3_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = rs3_pkg::MAX_HEIGHT_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic                       cfg_index,
    input  wire logic [rs3_pkg::CFG_W-1:0]  cfg_data,
    input  wire logic                       s_axis_tvalid,
    output logic                            s_axis_tready,
    input  wire logic [rs3_pkg::WORD_W-1:0] s_axis_tdata,  // in_blue, in_green, in_red
    input  wire logic                       s_axis_tuser,  // flush
    output logic                            m_axis_tvalid,
    input  wire logic                       m_axis_tready,
    output logic [rs3_pkg::WORD_W-1:0]      m_axis_tdata,  // out_blue, out_green, out_red
    output logic                            m_axis_tlast
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT + 2);
    localparam int DW0 = (CW > RW) ? CW : RW;
    localparam int DW  = ((DW0 > rs3_pkg::CFG_W) ? DW0 : rs3_pkg::CFG_W) + 2;
    localparam int WW  = rs3_pkg::WORD_W;

    logic [rs3_pkg::CFG_W-1:0] frame_width_reg, frame_height_reg;
    logic [CW-1:0]             col_count_reg, col_count_next;
    logic [RW-1:0]             row_count_reg, row_count_next;

    logic                      s1_valid_reg, s1_valid_next;
    rs3_pkg::pixel_t           s1_pix_reg;
    logic [CW-1:0]             s1_addr_reg;
    logic                      s1_res0_reg, s1_res1_reg, s1_end_reg;
    logic                      s1_lmask_reg, s1_tmask_reg;
    logic                      fwd_reg;
    rs3_pkg::pixel_t           fwd_a_reg, fwd_b_reg;
    rs3_pkg::win_t             win_reg, win_next;

    logic                      out_valid_reg, out_valid_next;
    rs3_pkg::pixel_t           out_data_reg;
    logic                      out_last_reg;

    logic                      accept, s1_adv, s1_has_res;
    logic [DW-1:0]             fw_ext, fh_ext, w_eff, h_eff, h_p1, c_ext, r_ext;
    logic                      res0, res1, frm_end, lmask, tmask;
    rs3_pkg::pixel_t           pix_v, t_word, m_word, kres;
    logic [2*WW-1:0]           mem_rd;
    rs3_pkg::win_t             nb;

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= rs3_pkg::DIM_RESET;
            frame_height_reg <= rs3_pkg::DIM_RESET;
        end
        else if (cfg_we)
        begin
            unique case (rs3_pkg::cfg_index_t'(cfg_index))
                rs3_pkg::CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                rs3_pkg::CFG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign fw_ext = DW'(frame_width_reg);
    assign fh_ext = DW'(frame_height_reg);
    assign w_eff  = (fw_ext == '0) ? DW'(1) :
                    (fw_ext > DW'(MAX_WIDTH)) ? DW'(MAX_WIDTH) : fw_ext;
    assign h_eff  = (fh_ext == '0) ? DW'(1) :
                    (fh_ext > DW'(MAX_HEIGHT)) ? DW'(MAX_HEIGHT) : fh_ext;
    assign h_p1   = h_eff + DW'(1);

    // ---------------- handshake ----------------
    assign s1_has_res    = s1_res0_reg || s1_res1_reg;
    assign s1_adv        = s1_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || s1_adv;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // ---------------- position decode at input ----------------
    assign c_ext   = DW'(col_count_reg);
    assign r_ext   = DW'(row_count_reg);
    assign res0    = (c_ext == '0) && (r_ext >= DW'(2)) && (r_ext <= h_p1);
    assign res1    = (c_ext != '0) && (r_ext >= DW'(1)) && (r_ext <= h_eff);
    assign frm_end = res0 && (r_ext == h_p1);
    assign lmask   = res1 ? (c_ext < DW'(2)) : (w_eff < DW'(2));
    assign tmask   = res1 ? (r_ext < DW'(2)) : (r_ext < DW'(3));
    assign pix_v   = (!s_axis_tuser && (r_ext < h_eff)) ? s_axis_tdata : '0;

    always_comb
    begin
        col_count_next = col_count_reg;
        row_count_next = row_count_reg;
        if (accept)
        begin
            if ((c_ext == '0) && (r_ext >= h_p1))
            begin
                col_count_next = '0;
                row_count_next = '0;
            end
            else if ((c_ext + DW'(1)) >= w_eff)
            begin
                col_count_next = '0;
                row_count_next = row_count_reg + RW'(1);
            end
            else
            begin
                col_count_next = col_count_reg + CW'(1);
            end
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
    end

    // ---------------- line stores ----------------
    rs3_line_buf #(
        .DEPTH (MAX_WIDTH),
        .WIDTH (2 * WW)
    ) u_line_buf (
        .clk   (clk),
        .we    (s1_adv),
        .waddr (s1_addr_reg),
        .wdata ({m_word, s1_pix_reg}),
        .re    (accept),
        .raddr (col_count_reg),
        .rdata (mem_rd)
    );

    // top of the column comes from store b, middle from store a
    assign t_word = fwd_reg ? fwd_b_reg : mem_rd[2*WW-1:WW];
    assign m_word = fwd_reg ? fwd_a_reg : mem_rd[WW-1:0];

    // ---------------- window ----------------
    always_comb
    begin
        win_next    = win_reg;
        win_next[0] = win_reg[3];
        win_next[1] = win_reg[4];
        win_next[2] = win_reg[5];
        win_next[3] = win_reg[6];
        win_next[4] = win_reg[7];
        win_next[5] = win_reg[8];
        win_next[6] = t_word;
        win_next[7] = m_word;
        win_next[8] = s1_pix_reg;
    end

    always_comb
    begin
        if (s1_res1_reg)
        begin
            nb = win_next;
        end
        else
        begin
            nb    = '0;
            nb[0] = win_reg[3];
            nb[1] = win_reg[4];
            nb[2] = win_reg[5];
            nb[3] = win_reg[6];
            nb[4] = win_reg[7];
            nb[5] = win_reg[8];
        end
        if (s1_lmask_reg)
        begin
            nb[0] = '0;
            nb[1] = '0;
            nb[2] = '0;
        end
        if (s1_tmask_reg)
        begin
            nb[0] = '0;
            nb[3] = '0;
            nb[6] = '0;
        end
    end

    rs3_kernel u_kernel (
        .nb     (nb),
        .result (kres)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_adv && s1_has_res)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= '0;
            row_count_reg <= '0;
            s1_valid_reg  <= 1'b0;
            s1_res0_reg   <= 1'b0;
            s1_res1_reg   <= 1'b0;
            fwd_reg       <= 1'b0;
            win_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                s1_res0_reg <= res0;
                s1_res1_reg <= res1;
                fwd_reg     <= s1_adv && (s1_addr_reg == col_count_reg);
            end
            if (s1_adv)
            begin
                win_reg <= win_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg   <= pix_v;
            s1_addr_reg  <= col_count_reg;
            s1_end_reg   <= frm_end;
            s1_lmask_reg <= lmask;
            s1_tmask_reg <= tmask;
            fwd_a_reg    <= s1_pix_reg;
            fwd_b_reg    <= m_word;
        end
        if (s1_adv && s1_has_res)
        begin
            out_data_reg <= kres;
            out_last_reg <= s1_end_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

`ifndef SYNTH
    a_res_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> !(s1_res0_reg && s1_res1_reg))
        else $error("both result kinds flagged for one transaction");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> s_axis_tready)
        else $error("input stalled with empty stage");

    a_no_lost_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && s1_has_res) |=> m_axis_tvalid)
        else $error("result dropped");

    a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (c_ext == '0) && (r_ext >= h_p1)) |=>
            ((col_count_reg == '0) && (row_count_reg == '0)))
        else $error("counters did not return to zero at frame end");
`endif

endmodule

`default_nettype wire

@@ rtl/rs3_line_buf.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rs3_line_buf: dual line store
// One write port and one registered read port; holds the two previous rows.
// ----------------------------------------------------------------------------
module rs3_line_buf #(
    parameter int DEPTH = rs3_pkg::MAX_WIDTH_DEF,
    parameter int WIDTH = 2 * rs3_pkg::WORD_W
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ rtl/rs3_kernel.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rs3_kernel: 3x3 sharpen kernel
// 9 x centre minus the eight neighbours, per channel, clamped to 0..255.
// ----------------------------------------------------------------------------
module rs3_kernel (
    input  wire rs3_pkg::win_t   nb,
    output rs3_pkg::pixel_t      result
);

    always_comb
    begin
        logic [11:0]        c9;
        logic [10:0]        nsum;
        logic signed [12:0] diff;
        logic [7:0]         ctr;
        result = '0;
        for (int k = 0; k < 3; k++)
        begin
            ctr  = nb[4][8*k +: 8];
            c9   = {1'b0, ctr, 3'b000} + {4'b0000, ctr};
            nsum = '0;
            for (int q = 0; q < 9; q++)
            begin
                if (q != 4)
                begin
                    nsum = nsum + {3'b000, nb[q][8*k +: 8]};
                end
            end
            diff = $signed({1'b0, c9}) - $signed({2'b00, nsum});
            if (diff[12])
            begin
                result[8*k +: 8] = 8'd0;
            end
            else if (diff[11:8] != 4'd0)
            begin
                result[8*k +: 8] = 8'd255;
            end
            else
            begin
                result[8*k +: 8] = diff[7:0];
            end
        end
    end

endmodule

`default_nettype wire
